>>> rtl/bbl_pkg.sv
package bbl_pkg;

  // Field widths
  localparam int SAMPLE_W = 32;
  localparam int CH_W     = 3;
  localparam int B0_W     = 23;
  localparam int COEF_W   = 24;
  localparam int WARM_W   = 8;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  // Q2.22 coefficients: fraction bits
  localparam int FRAC_BITS = 22;

  // Defaults
  localparam int CHANNELS_DEF = 8;
  localparam logic [WARM_W-1:0] WARMUP_RESET = 8'd20;
  localparam logic [WARM_W-1:0] WARMUP_MAX   = '1;

  // Saturation limits
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 32'sh8000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0     = 2'd0,
    REG_A1     = 2'd1,
    REG_A2     = 2'd2,
    REG_WARMUP = 2'd3
  } reg_idx_t;

  // One channel's history entry
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_t;

endpackage

>>> rtl/bbl_hist_ram.sv
module bbl_hist_ram
  import bbl_pkg::*;
#(
  parameter int DEPTH = CHANNELS_DEF,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output hist_t         rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  hist_t         wdata
);

  hist_t            mem [DEPTH];
  logic [DEPTH-1:0] vld;
  hist_t            q;
  logic             qv;

  // Storage, one port each way
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q  <= mem[raddr];
      qv <= vld[raddr];
    end
  end

  // Entry flags: an entry never written reads as zero history
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  assign rdata = qv ? q : '0;

endmodule

>>> rtl/bbl_mac.sv
module bbl_mac
  import bbl_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [SAMPLE_W-1:0] x,
  input  hist_t                      hist,
  input  logic        [B0_W-1:0]     b0,
  input  logic signed [COEF_W-1:0]   a1,
  input  logic signed [COEF_W-1:0]   a2,
  output logic signed [SAMPLE_W-1:0] y
);

  localparam int SX_W  = SAMPLE_W + 2;
  localparam int P0_W  = B0_W + 1 + SX_W;
  localparam int P1_W  = COEF_W + SAMPLE_W;
  localparam int ACC_W = P0_W + 2;
  localparam int Q_W   = ACC_W - FRAC_BITS;

  logic signed [SX_W-1:0]   sx;
  logic signed [B0_W:0]     b0s;
  logic signed [P0_W-1:0]   p0;
  logic signed [P1_W-1:0]   p1;
  logic signed [P1_W-1:0]   p2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [Q_W-1:0]    qv;
  logic [Q_W-SAMPLE_W:0]    top_bits;

  // Feed-forward tap sum x + 2*x1 + x2
  assign sx = SX_W'(x) + (SX_W'(hist.x1) <<< 1) + SX_W'(hist.x2);
  assign b0s = $signed({1'b0, b0});

  // Products, registered
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= b0s * sx;
      p1 <= a1 * hist.y1;
      p2 <= a2 * hist.y2;
    end
  end

  // Accumulate, round half up, drop fraction
  assign acc = ACC_W'(p0) - ACC_W'(p1) - ACC_W'(p2);
  assign rnd = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
  assign qv  = rnd[ACC_W-1:FRAC_BITS];
  assign top_bits = qv[Q_W-1:SAMPLE_W-1];

  // Saturate to 32 bits
  always_comb begin
    if ((top_bits == '0) || (top_bits == '1)) begin
      y = qv[SAMPLE_W-1:0];
    end else if (qv[Q_W-1]) begin
      y = SAT_MIN;
    end else begin
      y = SAT_MAX;
    end
  end

endmodule

>>> rtl/butterworth_biquad_lowpass_multichannel_top.sv
// Multichannel second-order low-pass filter, direct form I.
//
// Input request: sample, channel, vector_end, moved on in_valid & !in_stall.
// Output request: filtered, out_channel, bypassed, moved on out_valid & !out_stall.
// Coefficients and warm-up length are written through cfg_we/cfg_index/cfg_data
// while the block is idle.
//
// An accepted request passes through stage 1 (history read), stage 2 (MAC
// products) and the output register. Throughput is one request per cycle while
// the output does not stall and a channel recurs no sooner than every third
// request. Per-channel history sits in one synchronous RAM; a sample for a
// channel is held off until the previous sample of that channel has been
// written back, so the same channel in consecutive requests is stalled.
//
// Reset restores the default registers, clears the warm-up count and marks all
// history entries as zero. While the output is stalled the result holds and
// the pipeline keeps taking requests until its two internal stages are full.
module butterworth_biquad_lowpass_multichannel_top
  import bbl_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [CH_W-1:0]     channel,
  input  logic                       vector_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] filtered,
  output logic        [CH_W-1:0]     out_channel,
  output logic                       bypassed,
  input  logic                       cfg_we,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CFG_W-1:0]    cfg_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers
  logic        [B0_W-1:0]   coef_b0;
  logic signed [COEF_W-1:0] coef_a1;
  logic signed [COEF_W-1:0] coef_a2;
  logic        [WARM_W-1:0] warmup_calls;
  logic        [WARM_W-1:0] warmup_count;

  // Pipeline state
  logic                       s1_valid, s2_valid;
  logic signed [SAMPLE_W-1:0] s1_x, s2_x;
  logic        [CH_W-1:0]     s1_ch, s2_ch;
  logic                       s1_warm, s2_warm;
  logic                       s1_oor, s2_oor;
  hist_t                      s2_hist;

  logic                       en_o, en2, en1;
  logic                       in_range, hazard, accept, warm;
  hist_t                      rd_hist, wr_hist;
  logic                       wr_en;
  logic signed [SAMPLE_W-1:0] mac_y, y;
  logic                       byp;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0      <= '0;
      coef_a1      <= '0;
      coef_a2      <= '0;
      warmup_calls <= WARMUP_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_B0:     coef_b0      <= cfg_data[B0_W-1:0];
        REG_A1:     coef_a1      <= $signed(cfg_data[COEF_W-1:0]);
        REG_A2:     coef_a2      <= $signed(cfg_data[COEF_W-1:0]);
        REG_WARMUP: warmup_calls <= cfg_data[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables, from the output back
  assign en_o = !out_valid || !out_stall;
  assign en2  = en_o || !s2_valid;
  assign en1  = en2 || !s1_valid;

  // Interlock: same channel still in flight
  assign in_range = 32'(channel) < 32'(CHANNELS);
  assign hazard = in_range &&
                  ((s1_valid && !s1_oor && (s1_ch == channel)) ||
                   (s2_valid && !s2_oor && (s2_ch == channel)));
  assign in_stall = !en1 || hazard;
  assign accept   = in_valid && !in_stall;
  assign warm     = warmup_count < warmup_calls;

  // Warm-up count, advanced on the last channel of a vector
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_count <= '0;
    end else if (accept && warm && vector_end && (warmup_count != WARMUP_MAX)) begin
      warmup_count <= warmup_count + 1'b1;
    end
  end

  // Stage 1: history read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x    <= sample;
      s1_ch   <= channel;
      s1_warm <= warm;
      s1_oor  <= !in_range;
    end
  end

  bbl_hist_ram #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .re    (accept && in_range),
    .raddr (AW'(channel)),
    .rdata (rd_hist),
    .we    (wr_en),
    .waddr (AW'(s2_ch)),
    .wdata (wr_hist)
  );

  // Stage 2: products registered inside the MAC
  bbl_mac u_mac (
    .clk  (clk),
    .en   (en2),
    .x    (s1_x),
    .hist (rd_hist),
    .b0   (coef_b0),
    .a1   (coef_a1),
    .a2   (coef_a2),
    .y    (mac_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      s2_x    <= s1_x;
      s2_ch   <= s1_ch;
      s2_warm <= s1_warm;
      s2_oor  <= s1_oor;
      s2_hist <= rd_hist;
    end
  end

  // Result select and history write-back
  assign byp = s2_oor || s2_warm;
  assign y   = byp ? s2_x : mac_y;

  assign wr_en      = en2 && s2_valid && !s2_oor;
  assign wr_hist.x1 = s2_x;
  assign wr_hist.x2 = s2_hist.x1;
  assign wr_hist.y1 = y;
  assign wr_hist.y2 = s2_hist.y1;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_o) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && s2_valid) begin
      filtered    <= y;
      out_channel <= s2_ch;
      bypassed    <= byp;
    end
  end

endmodule

>>> rtl/bbl_checker.sv
module bbl_checker
  import bbl_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic        [CH_W-1:0]     channel,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] filtered,
  input logic        [CH_W-1:0]     out_channel,
  input logic                       bypassed
);

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid straight after reset");

  // An accepted request reaches out_valid when the output keeps moving
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted request did not reach the output");

  // Same channel right after a request must wait for its write-back
  a_interlock: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (32'(channel) < 32'(CHANNELS)))
    ##1 (in_valid && (channel == $past(channel))) |-> in_stall)
    else $error("same channel accepted while its history is in flight");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
    (out_valid && $stable(filtered) && $stable(out_channel) && $stable(bypassed)))
    else $error("stalled result changed");

endmodule

bind butterworth_biquad_lowpass_multichannel_top bbl_checker #(
  .CHANNELS (CHANNELS)
) u_bbl_checker (.*);

>>> tb/testbench.sv
module testbench;
  import bbl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = CHANNELS_DEF;
  // cycles with no request, result or register write before giving up
  localparam int STUCK_LIMIT = 1000;

  // Q2.22 coefficient sets: low-pass at 0.10, 0.25 and 0.02 of the sample rate
  localparam logic [B0_W-1:0]          LP10_B0 = 23'd282926;
  localparam logic signed [COEF_W-1:0] LP10_A1 = -24'sd4794021;
  localparam logic signed [COEF_W-1:0] LP10_A2 = 24'sd1731405;
  localparam logic [B0_W-1:0]          LP25_B0 = 23'd1228473;
  localparam logic signed [COEF_W-1:0] LP25_A1 = 24'sd0;
  localparam logic signed [COEF_W-1:0] LP25_A2 = 24'sd719617;
  localparam logic [B0_W-1:0]          LP02_B0 = 23'd15190;
  localparam logic signed [COEF_W-1:0] LP02_A1 = -24'sd7645000;
  localparam logic signed [COEF_W-1:0] LP02_A2 = 24'sd3511366;
  localparam logic [B0_W-1:0]          B0_ONE  = 23'd4194304;
  localparam logic signed [COEF_W-1:0] A_MAX   = 24'sh7f_ffff;
  localparam logic signed [COEF_W-1:0] A_MIN   = 24'sh80_0000;
  localparam logic signed [SAMPLE_W-1:0] HALF_LSB_X = 32'sd524288;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic        [CH_W-1:0]     ch;
    logic                       vend;
    bit                         hold;  // wait for all results before sending
  } lp_req_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] val;
    logic        [CH_W-1:0]     ch;
    logic                       byp;
  } lp_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic [CH_W-1:0] channel = '0;
  logic vector_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered;
  logic [CH_W-1:0] out_channel;
  logic bypassed;
  logic cfg_we = 1'b0;
  reg_idx_t cfg_index = REG_B0;
  logic [CFG_W-1:0] cfg_data = '0;

  butterworth_biquad_lowpass_multichannel_top dut (.*);

  // filter copy: coefficients, warm-up and per-channel history
  logic [B0_W-1:0]            coef_b0;
  logic signed [COEF_W-1:0]   coef_a1, coef_a2;
  logic [WARM_W-1:0]          warm_calls, warm_count;
  logic signed [SAMPLE_W-1:0] hist_x1[NCH], hist_x2[NCH], hist_y1[NCH], hist_y2[NCH];

  lp_req_t req_backlog[$];
  lp_res_t due_results[$];
  lp_req_t next_req, seen_req;
  lp_res_t due;
  logic req_taken = 1'b0, res_taken = 1'b0;
  int send_wait = 0, recv_wait = 0;
  int in_gap_max = 3, out_gap_max = 3;
  int errors = 0, stuck = 0;
  int n_warm = 0, n_filt = 0, n_clip = 0, n_settings = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // one sample through the filter, updating history and warm-up count
  function automatic lp_res_t filter_sample(input lp_req_t r);
    lp_res_t res;
    logic signed [63:0] x, x1, x2, y1, y2, b0, a1, a2, acc, q;
    logic warm;
    x = r.smp;
    res.ch = r.ch;
    res.val = r.smp;
    res.byp = 1'b1;
    warm = warm_count < warm_calls;
    if (int'(r.ch) >= NCH) begin
      // no such channel: straight through, history untouched
    end else if (warm) begin
      hist_x2[r.ch] = hist_x1[r.ch];
      hist_x1[r.ch] = r.smp;
      hist_y2[r.ch] = hist_y1[r.ch];
      hist_y1[r.ch] = r.smp;
      n_warm++;
    end else begin
      x1 = hist_x1[r.ch];
      x2 = hist_x2[r.ch];
      y1 = hist_y1[r.ch];
      y2 = hist_y2[r.ch];
      b0 = coef_b0;
      a1 = coef_a1;
      a2 = coef_a2;
      acc = b0 * (x + (x1 <<< 1) + x2) - a1 * y1 - a2 * y2;
      // round half up, then clip to 32 bits
      q = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (q > SAT_MAX) begin
        res.val = SAT_MAX;
        n_clip++;
      end else if (q < SAT_MIN) begin
        res.val = SAT_MIN;
        n_clip++;
      end else begin
        res.val = q[SAMPLE_W-1:0];
      end
      res.byp = 1'b0;
      hist_x2[r.ch] = hist_x1[r.ch];
      hist_x1[r.ch] = r.smp;
      hist_y2[r.ch] = hist_y1[r.ch];
      hist_y1[r.ch] = res.val;
      n_filt++;
    end
    if (warm && r.vend && warm_count != WARMUP_MAX) warm_count++;
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 15))
      0: begin
        case ($urandom_range(0, 4))
          0: return SAT_MAX;
          1: return SAT_MIN;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2: return $urandom;
      default: begin
        // within +/-1024 in Q16.16
        v = $urandom_range(0, 134217727);
        return v - 67108864;
      end
    endcase
  endfunction

  task automatic queue_req(input logic signed [SAMPLE_W-1:0] smp, input logic [CH_W-1:0] ch,
                           input logic vend, input bit hold);
    lp_req_t r;
    r.smp = smp;
    r.ch = ch;
    r.vend = vend;
    r.hold = hold;
    req_backlog.push_back(r);
  endtask

  // runs of consecutive channels closed by the end flag, with stray requests mixed in
  task automatic gen_vectors(input int n_items, input int max_len);
    int done, len, first;
    bit held, h;
    done = 0;
    held = 1'b0;
    while (done < n_items) begin
      h = ($urandom_range(0, 63) == 0);
      if (!held && done >= n_items / 2) begin
        h = 1'b1;
        held = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        queue_req(pick_sample(), CH_W'($urandom_range(0, NCH - 1)),
                  1'($urandom_range(0, 1)), h);
        done++;
      end else begin
        len = $urandom_range(1, max_len);
        first = $urandom_range(0, NCH - len);
        for (int k = 0; k < len; k++)
          queue_req(pick_sample(), CH_W'(first + k), k == len - 1, k == 0 && h);
        done += len;
      end
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_filter(input logic [B0_W-1:0] b0, input logic signed [COEF_W-1:0] a1,
                            input logic signed [COEF_W-1:0] a2, input logic [WARM_W-1:0] warm);
    write_reg(REG_B0, CFG_W'(b0));
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_WARMUP, CFG_W'(warm));
    coef_b0 = b0;
    coef_a1 = a1;
    coef_a2 = a2;
    warm_calls = warm;
    n_settings++;
  endtask

  // everything sent and every result back
  task automatic wait_idle();
    while (req_backlog.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else if (!in_valid || req_taken) begin
      if (send_wait > 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (req_backlog.size() != 0 &&
                   !(req_backlog[0].hold && due_results.size() != 0)) begin
        next_req = req_backlog.pop_front();
        sample <= next_req.smp;
        channel <= next_req.ch;
        vector_end <= next_req.vend;
        in_valid <= 1'b1;
        send_wait = $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side stall, drawn afresh after each result
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (res_taken) recv_wait = $urandom_range(0, out_gap_max);
      if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: check results, predict accepted requests
  always @(posedge clk) begin
    req_taken <= !rst && in_valid && !in_stall;
    res_taken <= !rst && out_valid && !out_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result with nothing outstanding: filtered %0d, channel %0d",
                 filtered, out_channel);
          errors++;
        end else begin
          due = due_results.pop_front();
          if (filtered !== due.val) begin
            $error("filtered: expected %0d, got %0d", due.val, filtered);
            errors++;
          end
          if (out_channel !== due.ch) begin
            $error("out_channel: expected %0d, got %0d", due.ch, out_channel);
            errors++;
          end
          if (bypassed !== due.byp) begin
            $error("bypassed: expected %0d, got %0d", due.byp, bypassed);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen_req.smp = sample;
        seen_req.ch = channel;
        seen_req.vend = vector_end;
        seen_req.hold = 1'b0;
        due_results.push_back(filter_sample(seen_req));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    int ph;
    coef_b0 = '0;
    coef_a1 = '0;
    coef_a2 = '0;
    warm_calls = WARMUP_RESET;
    warm_count = '0;
    for (int c = 0; c < NCH; c++) begin
      hist_x1[c] = '0;
      hist_x2[c] = '0;
      hist_y1[c] = '0;
      hist_y2[c] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: still in warm-up, extremes go straight through
    queue_req(SAT_MAX, 3'd0, 1'b0, 1'b0);
    queue_req(SAT_MIN, 3'd1, 1'b0, 1'b0);
    queue_req(32'sd0, 3'd2, 1'b0, 1'b0);
    queue_req(-32'sd1, 3'd3, 1'b0, 1'b0);
    queue_req(32'sd1, 3'd4, 1'b0, 1'b0);
    queue_req(32'sh0001_0000, 3'd5, 1'b0, 1'b0);
    queue_req(32'sh5555_5555, 3'd6, 1'b0, 1'b0);
    queue_req(32'shAAAA_AAAA, 3'd7, 1'b1, 1'b0);
    wait_idle();

    // unity b0, no feedback, no warm-up: full-scale input clips both ways
    set_filter(B0_ONE, 24'sd0, 24'sd0, 8'd0);
    queue_req(SAT_MAX, 3'd0, 1'b0, 1'b0);
    queue_req(SAT_MIN, 3'd1, 1'b0, 1'b0);
    queue_req(SAT_MAX, 3'd0, 1'b0, 1'b0);
    queue_req(SAT_MIN, 3'd1, 1'b0, 1'b0);
    queue_req(32'sd0, 3'd2, 1'b1, 1'b0);
    wait_idle();

    // smallest b0: sums of exactly half an LSB round up on both signs
    set_filter(23'd1, 24'sd0, 24'sd0, 8'd0);
    repeat (3) queue_req(HALF_LSB_X, 3'd7, 1'b0, 1'b0);
    repeat (3) queue_req(-HALF_LSB_X, 3'd6, 1'b1, 1'b0);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_filter(LP10_B0, LP10_A1, LP10_A2, warm_count + 8'd4);
        1: set_filter(LP25_B0, LP25_A1, LP25_A2, warm_count);
        2: set_filter(LP02_B0, LP02_A1, LP02_A2, warm_count);
        3: set_filter(B0_W'($urandom_range(0, 4194304)), COEF_W'($urandom),
                      COEF_W'($urandom), warm_count + WARM_W'($urandom_range(0, 3)));
        4: set_filter(LP10_B0, LP10_A1, LP10_A2, WARMUP_MAX);
        5: set_filter(B0_ONE, A_MIN, A_MAX, 8'd0);
        6: set_filter(23'd0, A_MAX, A_MIN, 8'd0);
        default: set_filter(LP25_B0, LP25_A1, LP25_A2, WARMUP_MAX);
      endcase
      in_gap_max = (ph == 1 || ph == 5) ? 0 : 3;
      out_gap_max = (ph == 1 || ph == 6) ? 0 : 3;
      // one-channel vectors drive the warm-up count to its ceiling
      gen_vectors(ph == 4 ? 420 : 140, ph == 4 ? 1 : (ph == 2 ? 4 : NCH));
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d requests over %0d coefficient settings: %0d in warm-up, %0d filtered",
             n_warm + n_filt, n_settings, n_warm, n_filt);
    $display("%0d results clipped to full scale; warm-up count ended at %0d", n_clip,
             warm_count);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> butterworth_biquad_lowpass_multichannel_top.f
rtl/bbl_pkg.sv
rtl/bbl_hist_ram.sv
rtl/bbl_mac.sv
rtl/butterworth_biquad_lowpass_multichannel_top.sv
rtl/bbl_checker.sv
tb/testbench.sv
